>>> rtl/plg_pkg.sv
// Shared constants and stage control types for the polygon area statistics unit.
package plg_pkg;

	localparam int COORD_W   = 16;
	localparam int ACC_W     = 50;
	localparam int AREA_W    = 33;
	localparam int SUM_W     = 60;
	localparam int VCNT_W    = 16;
	localparam int CNT_OUT_W = 24;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 400;

	localparam logic [VCNT_W-1:0] VCNT_MAX     = {VCNT_W{1'b1}};
	localparam logic [VCNT_W-1:0] MIN_VERTS    = 16'd3;
	localparam logic [VCNT_W-1:0] TARGET_RESET = 16'd3;
	localparam logic [AREA_W-1:0] AREA_MAX     = {AREA_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};

	// Control bits that travel with a vertex through the front stages.
	typedef struct packed {
		logic valid;
		logic last;
		logic head;
	} vtx_ctl_t;

	// Control bits that reach the statistics stage.
	typedef struct packed {
		logic valid;
		logic done;
	} res_ctl_t;

endpackage

>>> rtl/plg_vertex_stage.sv
// Input register, ring state (first, previous, count) and the four cross-product multipliers.
module plg_vertex_stage #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_valid,
	input  logic signed [plg_pkg::COORD_W-1:0]   x_coord,
	input  logic signed [plg_pkg::COORD_W-1:0]   y_coord,
	input  logic                                 last_vertex,
	output plg_pkg::vtx_ctl_t                    ctl_s2,
	output logic        [plg_pkg::VCNT_W-1:0]    n_s2,
	output logic signed [2*COORD_BITS-1:0]       p0_s2,
	output logic signed [2*COORD_BITS-1:0]       p1_s2,
	output logic signed [2*COORD_BITS-1:0]       p2_s2,
	output logic signed [2*COORD_BITS-1:0]       p3_s2
);
	import plg_pkg::*;

	localparam int EXT_W = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;

	logic                       v_s1;
	logic                       last_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic        [VCNT_W-1:0]   vcnt_q;

	logic        [EXT_W-1:0]      x_ext, y_ext;
	logic signed [COORD_BITS-1:0] x_cur, y_cur;
	logic signed [COORD_BITS-1:0] fx, fy;
	logic                         head;
	logic        [VCNT_W-1:0]     n_next;
	logic                         step;

	// take the low COORD_BITS of the field as two's complement
	assign x_ext = EXT_W'($unsigned(x_coord));
	assign y_ext = EXT_W'($unsigned(y_coord));
	assign x_cur = signed'(x_ext[COORD_BITS-1:0]);
	assign y_cur = signed'(y_ext[COORD_BITS-1:0]);

	assign step   = adv && v_s1;
	assign head   = (vcnt_q == '0);
	assign fx     = head ? x_s1 : first_x_q;
	assign fy     = head ? y_s1 : first_y_q;
	assign n_next = (vcnt_q == VCNT_MAX) ? vcnt_q : vcnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			ctl_s2    <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			vcnt_q    <= '0;
		end else if (adv) begin
			v_s1   <= in_valid;
			ctl_s2 <= '{valid: v_s1, last: last_s1, head: head};
			if (v_s1) begin
				prev_x_q <= x_s1;
				prev_y_q <= y_s1;
				if (head) begin
					first_x_q <= x_s1;
					first_y_q <= y_s1;
				end
				vcnt_q <= last_s1 ? '0 : n_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_cur;
			y_s1    <= y_cur;
			last_s1 <= last_vertex;
		end
		if (step) begin
			n_s2  <= n_next;
			p0_s2 <= prev_x_q * y_s1;
			p1_s2 <= x_s1 * prev_y_q;
			p2_s2 <= x_s1 * fy;
			p3_s2 <= fx * y_s1;
		end
	end

endmodule

>>> rtl/plg_accum.sv
// Cross terms, saturating shoelace accumulator and absolute area.
module plg_accum #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  plg_pkg::vtx_ctl_t                    ctl_s2,
	input  logic        [plg_pkg::VCNT_W-1:0]    n_s2,
	input  logic signed [2*COORD_BITS-1:0]       p0_s2,
	input  logic signed [2*COORD_BITS-1:0]       p1_s2,
	input  logic signed [2*COORD_BITS-1:0]       p2_s2,
	input  logic signed [2*COORD_BITS-1:0]       p3_s2,
	output plg_pkg::res_ctl_t                    res_s5,
	output logic        [plg_pkg::AREA_W-1:0]    area_s5,
	output logic        [plg_pkg::VCNT_W-1:0]    n_s5
);
	import plg_pkg::*;

	localparam int TW = 2*COORD_BITS + 1;
	localparam int SW = ((TW > ACC_W) ? TW : ACC_W) + 1;
	localparam logic signed [SW-1:0] ACC_LIM = SW'((64'd1 << (ACC_W-1)) - 64'd1);

	vtx_ctl_t                 ctl_s3;
	logic        [VCNT_W-1:0] n_s3, n_s4;
	logic signed [TW-1:0]     t1_s3, t2_s3;
	logic                     v_s4, last_s4;
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [TW-1:0]     t1, t2;
	logic signed [SW-1:0]     sum1, sum2, sat1, sat2;
	logic signed [ACC_W-1:0]  acc1, acc2;
	logic        [ACC_W-1:0]  mag;
	logic        [AREA_W-1:0] area;

	assign t1 = ctl_s2.head ? '0 : TW'(p0_s2) - TW'(p1_s2);
	assign t2 = ctl_s2.last ? TW'(p2_s2) - TW'(p3_s2) : '0;

	// clamp to the symmetric accumulator range after each add
	always_comb begin
		sum1 = SW'(acc_q) + SW'(t1_s3);
		if (sum1 > ACC_LIM)
			sat1 = ACC_LIM;
		else if (sum1 < -ACC_LIM)
			sat1 = -ACC_LIM;
		else
			sat1 = sum1;
		acc1 = ACC_W'(sat1);
		sum2 = SW'(acc1) + SW'(t2_s3);
		if (sum2 > ACC_LIM)
			sat2 = ACC_LIM;
		else if (sum2 < -ACC_LIM)
			sat2 = -ACC_LIM;
		else
			sat2 = sum2;
		acc2 = ACC_W'(sat2);
	end

	assign mag  = (acc_s4 < 0) ? $unsigned(-acc_s4) : $unsigned(acc_s4);
	assign area = (|mag[ACC_W-1:AREA_W]) ? AREA_MAX : mag[AREA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			v_s4   <= 1'b0;
			res_s5 <= '0;
			acc_q  <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
			v_s4   <= ctl_s3.valid;
			res_s5 <= '{valid: v_s4, done: last_s4 && (n_s4 >= MIN_VERTS)};
			if (ctl_s3.valid)
				acc_q <= ctl_s3.last ? '0 : acc2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s3   <= t1;
			t2_s3   <= t2;
			n_s3    <= n_s2;
			last_s4 <= ctl_s3.last;
			acc_s4  <= acc2;
			n_s4    <= n_s3;
			area_s5 <= area;
			n_s5    <= n_s4;
		end
	end

endmodule

>>> rtl/plg_stats.sv
// Running set statistics, output register and pipeline advance control.
module plg_stats #(
	parameter int COUNT_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  plg_pkg::res_ctl_t                  res_s5,
	input  logic [plg_pkg::AREA_W-1:0]         area_s5,
	input  logic [plg_pkg::VCNT_W-1:0]         n_s5,
	input  logic [plg_pkg::VCNT_W-1:0]         target,
	input  logic                               out_ready,
	output logic                               adv,
	output logic                               out_valid,
	output logic [plg_pkg::AREA_W-1:0]         twice_area,
	output logic [plg_pkg::VCNT_W-1:0]         vertex_total,
	output logic [plg_pkg::CNT_OUT_W-1:0]      polygon_count,
	output logic [plg_pkg::CNT_OUT_W-1:0]      even_count,
	output logic [plg_pkg::CNT_OUT_W-1:0]      target_count,
	output logic [plg_pkg::SUM_W-1:0]          even_area_sum,
	output logic [plg_pkg::SUM_W-1:0]          odd_area_sum,
	output logic [plg_pkg::SUM_W-1:0]          target_area_sum,
	output logic [plg_pkg::AREA_W-1:0]         least_area,
	output logic [plg_pkg::AREA_W-1:0]         greatest_area,
	output logic [plg_pkg::VCNT_W-1:0]         least_vertices,
	output logic [plg_pkg::VCNT_W-1:0]         greatest_vertices
);
	import plg_pkg::*;

	localparam int CXW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] valid_q, even_q, target_q;
	logic                  retire, out_free, load, is_even, is_target;
	logic [SUM_W:0]        even_add, odd_add, target_add;
	logic [CXW-1:0]        valid_x, even_x, target_x;

	assign retire   = res_s5.valid && res_s5.done;
	assign out_free = !out_valid || out_ready;
	assign adv      = !retire || out_free;
	assign load     = retire && out_free;

	assign is_even   = !n_s5[0];
	assign is_target = (n_s5 == target);

	assign even_add   = {1'b0, even_area_sum}   + (SUM_W+1)'(area_s5);
	assign odd_add    = {1'b0, odd_area_sum}    + (SUM_W+1)'(area_s5);
	assign target_add = {1'b0, target_area_sum} + (SUM_W+1)'(area_s5);

	// counts saturate at their own width, then show the low field bits
	assign valid_x       = CXW'(valid_q);
	assign even_x        = CXW'(even_q);
	assign target_x      = CXW'(target_q);
	assign polygon_count = valid_x[CNT_OUT_W-1:0];
	assign even_count    = even_x[CNT_OUT_W-1:0];
	assign target_count  = target_x[CNT_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid         <= 1'b0;
			valid_q           <= '0;
			even_q            <= '0;
			target_q          <= '0;
			even_area_sum     <= '0;
			odd_area_sum      <= '0;
			target_area_sum   <= '0;
			least_area        <= AREA_MAX;
			greatest_area     <= '0;
			least_vertices    <= VCNT_MAX;
			greatest_vertices <= '0;
		end else begin
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (load) begin
				if (valid_q != CNT_MAX)
					valid_q <= valid_q + 1'b1;
				if (is_even) begin
					if (even_q != CNT_MAX)
						even_q <= even_q + 1'b1;
					even_area_sum <= even_add[SUM_W] ? SUM_MAX : even_add[SUM_W-1:0];
				end else begin
					odd_area_sum <= odd_add[SUM_W] ? SUM_MAX : odd_add[SUM_W-1:0];
				end
				if (is_target) begin
					if (target_q != CNT_MAX)
						target_q <= target_q + 1'b1;
					target_area_sum <= target_add[SUM_W] ? SUM_MAX : target_add[SUM_W-1:0];
				end
				if (area_s5 < least_area)
					least_area <= area_s5;
				if (area_s5 > greatest_area)
					greatest_area <= area_s5;
				if (n_s5 < least_vertices)
					least_vertices <= n_s5;
				if (n_s5 > greatest_vertices)
					greatest_vertices <= n_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			twice_area   <= area_s5;
			vertex_total <= n_s5;
		end
	end

endmodule

>>> rtl/polygon_area_statistics_unit.sv
// Top level of the polygon area statistics unit: stream ports, target register and stage wiring.
//
// Streams polygon vertices, one beat per vertex, with tlast on each polygon's final vertex,
// and returns one result beat per finished polygon of three or more vertices: twice its
// absolute shoelace area, its vertex count and the running set statistics (counts, even,
// odd and target-count area sums, least and greatest area and vertex count), all updated
// with the polygon itself. Shorter polygons are dropped silently. A vertex beat is taken in
// every cycle unless the output holds the pipeline; the datapath is a five-stage pipeline
// (input register, four parallel cross-product multipliers, term register, saturating
// accumulator, area magnitude) ahead of the statistics and output register. The output
// register lets the pipeline run on while a result beat waits; input stalls only when that
// beat and the next finished polygon both wait. Write target_vertices through
// cfg_wen/cfg_wdata only while the unit is idle; it resets to 3.
module polygon_area_statistics_unit #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// vertex stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [plg_pkg::TDATA_IN_W-1:0]      s_tdata,  // x_coord[15:0], y_coord[31:16]
	input  logic                                s_tlast,  // last_vertex
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// twice_area[32:0], vertex_total[48:33], polygon_count[72:49], even_count[96:73],
	// target_count[120:97], even_area_sum[180:121], odd_area_sum[240:181],
	// target_area_sum[300:241], least_area[333:301], greatest_area[366:334],
	// least_vertices[382:367], greatest_vertices[398:383], zero pad[399]
	output logic [plg_pkg::TDATA_OUT_W-1:0]     m_tdata,
	// target_vertices write port
	input  logic                                cfg_wen,
	input  logic [plg_pkg::VCNT_W-1:0]          cfg_wdata
);
	import plg_pkg::*;

	logic                           adv;
	logic [VCNT_W-1:0]              target_vertices_q;

	vtx_ctl_t                       ctl_s2;
	logic        [VCNT_W-1:0]       n_s2;
	logic signed [2*COORD_BITS-1:0] p0_s2, p1_s2, p2_s2, p3_s2;

	res_ctl_t                       res_s5;
	logic        [AREA_W-1:0]       area_s5;
	logic        [VCNT_W-1:0]       n_s5;

	logic [AREA_W-1:0]    twice_area, least_area, greatest_area;
	logic [VCNT_W-1:0]    vertex_total, least_vertices, greatest_vertices;
	logic [CNT_OUT_W-1:0] polygon_count, even_count, target_count;
	logic [SUM_W-1:0]     even_area_sum, odd_area_sum, target_area_sum;

	// the whole front pipeline advances together; hold it only on a blocked result
	assign s_tready = adv;

	// target register: take every write strobe, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_vertices_q <= TARGET_RESET;
		else if (cfg_wen)
			target_vertices_q <= cfg_wdata;
	end

	plg_vertex_stage #(
		.COORD_BITS (COORD_BITS)
	) u_vertex (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (s_tvalid),
		.x_coord     (signed'(s_tdata[15:0])),
		.y_coord     (signed'(s_tdata[31:16])),
		.last_vertex (s_tlast),
		.ctl_s2      (ctl_s2),
		.n_s2        (n_s2),
		.p0_s2       (p0_s2),
		.p1_s2       (p1_s2),
		.p2_s2       (p2_s2),
		.p3_s2       (p3_s2)
	);

	plg_accum #(
		.COORD_BITS (COORD_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s2  (ctl_s2),
		.n_s2    (n_s2),
		.p0_s2   (p0_s2),
		.p1_s2   (p1_s2),
		.p2_s2   (p2_s2),
		.p3_s2   (p3_s2),
		.res_s5  (res_s5),
		.area_s5 (area_s5),
		.n_s5    (n_s5)
	);

	plg_stats #(
		.COUNT_BITS (COUNT_BITS)
	) u_stats (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_s5            (res_s5),
		.area_s5           (area_s5),
		.n_s5              (n_s5),
		.target            (target_vertices_q),
		.out_ready         (m_tready),
		.adv               (adv),
		.out_valid         (m_tvalid),
		.twice_area        (twice_area),
		.vertex_total      (vertex_total),
		.polygon_count     (polygon_count),
		.even_count        (even_count),
		.target_count      (target_count),
		.even_area_sum     (even_area_sum),
		.odd_area_sum      (odd_area_sum),
		.target_area_sum   (target_area_sum),
		.least_area        (least_area),
		.greatest_area     (greatest_area),
		.least_vertices    (least_vertices),
		.greatest_vertices (greatest_vertices)
	);

	// pack the result beat, first field in the lowest bits
	assign m_tdata = {1'b0, greatest_vertices, least_vertices, greatest_area, least_area,
		target_area_sum, odd_area_sum, even_area_sum, target_count, even_count,
		polygon_count, vertex_total, twice_area};

endmodule

>>> tb/sv/polygon_area_statistics_unit_tb.sv
// Self-checking stream testbench for the polygon area statistics unit.
`timescale 1ns / 1ps

module polygon_area_statistics_unit_tb;

	localparam longint AREA_TOP  = (longint'(1) << plg_pkg::AREA_W) - 1;
	localparam longint SUM_TOP   = (longint'(1) << plg_pkg::SUM_W) - 1;
	localparam longint CNT_TOP   = (longint'(1) << plg_pkg::CNT_OUT_W) - 1;
	localparam longint ACC_TOP   = (longint'(1) << (plg_pkg::ACC_W - 1)) - 1;
	localparam int     VCNT_TOP  = int'(plg_pkg::VCNT_MAX);
	localparam int     QUIET_MAX = 2000;
	localparam int     SETTLE    = 12;
	localparam logic [15:0] C_HI = 16'h7FFF;
	localparam logic [15:0] C_LO = 16'h8000;

	// One vertex beat waiting to be sent.
	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
		logic        last;
	} vertex_t;

	// Result beat laid out as on m_tdata, highest field first.
	typedef struct packed {
		logic        pad;
		logic [15:0] verts_hi;
		logic [15:0] verts_lo;
		logic [32:0] area_hi;
		logic [32:0] area_lo;
		logic [59:0] hit_sum;
		logic [59:0] odd_sum;
		logic [59:0] even_sum;
		logic [23:0] hits;
		logic [23:0] evens;
		logic [23:0] polys;
		logic [15:0] nverts;
		logic [32:0] area;
	} poly_stats_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [plg_pkg::TDATA_IN_W-1:0]   s_tdata = '0;
	logic                             s_tlast = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [plg_pkg::TDATA_OUT_W-1:0]  m_tdata;
	logic                             cfg_wen = 1'b0;
	logic [plg_pkg::VCNT_W-1:0]       cfg_wdata = '0;

	vertex_t     vertex_q[$];
	poly_stats_t polygon_stats_q[$];
	int          unsent = 0;
	int          errors = 0;
	bit          jitter_on = 1'b1;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          quiet = 0;

	// Predictor state: ring start, previous vertex, shoelace sum and set statistics.
	longint      ring_x0 = 0, ring_y0 = 0, tail_x = 0, tail_y = 0, shoe_acc = 0;
	int          vtx_cnt = 0;
	longint      poly_n = 0, even_n = 0, hit_n = 0;
	longint      even_acc = 0, odd_acc = 0, hit_acc = 0;
	longint      area_lo = AREA_TOP, area_hi = 0;
	int          verts_lo = VCNT_TOP, verts_hi = 0;
	logic [15:0] target_copy = plg_pkg::TARGET_RESET;

	poly_stats_t got, want;

	polygon_area_statistics_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip_add(input longint a, input longint b, input longint top);
		return (a + b > top) ? top : a + b;
	endfunction

	function automatic longint clamp_acc(input longint v);
		if (v > ACC_TOP)
			return ACC_TOP;
		if (v < -ACC_TOP)
			return -ACC_TOP;
		return v;
	endfunction

	// Advance the shoelace sum by one vertex; queue a result when a valid ring closes.
	task automatic shoelace_step(input logic [31:0] beat, input logic closes);
		longint px, py, mag;
		int n;
		poly_stats_t r;
		px = longint'($signed(beat[15:0]));
		py = longint'($signed(beat[31:16]));
		if (vtx_cnt == 0) begin
			ring_x0 = px;
			ring_y0 = py;
		end else begin
			shoe_acc = clamp_acc(shoe_acc + tail_x * py - px * tail_y);
		end
		tail_x = px;
		tail_y = py;
		if (vtx_cnt < VCNT_TOP)
			vtx_cnt++;
		if (!closes)
			return;
		shoe_acc = clamp_acc(shoe_acc + px * ring_y0 - ring_x0 * py);
		n = vtx_cnt;
		mag = (shoe_acc < 0) ? -shoe_acc : shoe_acc;
		if (mag > AREA_TOP)
			mag = AREA_TOP;
		shoe_acc = 0;
		vtx_cnt = 0;
		if (n < int'(plg_pkg::MIN_VERTS))
			return;
		poly_n = clip_add(poly_n, 1, CNT_TOP);
		if (n % 2 == 0) begin
			even_n = clip_add(even_n, 1, CNT_TOP);
			even_acc = clip_add(even_acc, mag, SUM_TOP);
		end else begin
			odd_acc = clip_add(odd_acc, mag, SUM_TOP);
		end
		if (n == int'(target_copy)) begin
			hit_n = clip_add(hit_n, 1, CNT_TOP);
			hit_acc = clip_add(hit_acc, mag, SUM_TOP);
		end
		if (mag < area_lo)
			area_lo = mag;
		if (mag > area_hi)
			area_hi = mag;
		if (n < verts_lo)
			verts_lo = n;
		if (n > verts_hi)
			verts_hi = n;
		r.pad      = 1'b0;
		r.area     = mag[32:0];
		r.nverts   = n[15:0];
		r.polys    = poly_n[23:0];
		r.evens    = even_n[23:0];
		r.hits     = hit_n[23:0];
		r.even_sum = even_acc[59:0];
		r.odd_sum  = odd_acc[59:0];
		r.hit_sum  = hit_acc[59:0];
		r.area_lo  = area_lo[32:0];
		r.area_hi  = area_hi[32:0];
		r.verts_lo = verts_lo[15:0];
		r.verts_hi = verts_hi[15:0];
		polygon_stats_q.insert(polygon_stats_q.size(), r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		if (seen !== wanted)
			report_mismatch(what, seen, wanted);
	endtask

	// Driver: present the next pending vertex, with random gaps between beats.
	always @(posedge clk) begin
		vertex_t nxt;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (vertex_q.size() != 0) begin
				nxt = vertex_q.pop_front();
				s_tdata  <= {nxt.y, nxt.x};
				s_tlast  <= nxt.last;
				s_tvalid <= 1'b1;
				if (jitter_on && $urandom_range(0, 15) == 0)
					send_gap = $urandom_range(1, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: stall in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (jitter_on && $urandom_range(0, 11) == 0)
					recv_gap = $urandom_range(1, 18);
			end
		end
	end

	// Monitor: predict on each vertex beat, check each result beat against the oldest one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				shoelace_step(s_tdata, s_tlast);
				unsent--;
			end
			if (m_tvalid && m_tready) begin
				got = poly_stats_t'(m_tdata);
				if (polygon_stats_q.size() == 0) begin
					report_mismatch("result beat with no polygon pending", got.area, '0);
				end else begin
					want = polygon_stats_q.pop_front();
					check_field("twice_area", got.area, want.area);
					check_field("vertex_total", got.nverts, want.nverts);
					check_field("polygon_count", got.polys, want.polys);
					check_field("even_count", got.evens, want.evens);
					check_field("target_count", got.hits, want.hits);
					check_field("even_area_sum", got.even_sum, want.even_sum);
					check_field("odd_area_sum", got.odd_sum, want.odd_sum);
					check_field("target_area_sum", got.hit_sum, want.hit_sum);
					check_field("least_area", got.area_lo, want.area_lo);
					check_field("greatest_area", got.area_hi, want.area_hi);
					check_field("least_vertices", got.verts_lo, want.verts_lo);
					check_field("greatest_vertices", got.verts_hi, want.verts_hi);
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("FAIL polygon_area_statistics_unit");
				$finish;
			end
		end
	end

	task automatic add_vertex(input logic [15:0] x, input logic [15:0] y, input logic last);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.last = last;
		vertex_q.insert(vertex_q.size(), v);
		unsent++;
	endtask

	function automatic logic [15:0] pick_coord(input int style);
		case (style)
			1: return 16'($urandom_range(0, 400) - 200);
			2: begin
				case ($urandom_range(0, 3))
					0: return C_LO;
					1: return C_HI;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed rings of 3 to 8 vertices, some short ones, a few long ones.
	task automatic random_polygons(input int budget);
		int n, style;
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = 2;
				8: n = $urandom_range(9, 40);
				default: n = $urandom_range(3, 8);
			endcase
			style = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				add_vertex(pick_coord(style), pick_coord(style), i == n - 1);
			budget -= n;
		end
	endtask

	// Hold the sender until every result is in and the pipeline has emptied.
	task automatic settle();
		while (unsent != 0 || polygon_stats_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_target(input logic [15:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		target_copy = value;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] cx[4];
		logic [15:0] cy[4];
		cx = '{C_HI, C_LO, C_LO, C_HI};
		cy = '{C_HI, C_HI, C_LO, C_LO};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_target(16'd4);
		// extreme triangle
		add_vertex(C_LO, C_LO, 1'b0);
		add_vertex(C_HI, C_LO, 1'b0);
		add_vertex(C_HI, C_HI, 1'b1);
		// short polygons: one and two vertices
		add_vertex(C_HI, C_LO, 1'b1);
		add_vertex(16'd1, 16'd2, 1'b0);
		add_vertex(16'd3, 16'd4, 1'b1);
		// full square, even count, matches the target
		for (int i = 0; i < 4; i++)
			add_vertex(cx[i], cy[i], i == 3);
		// clockwise triangle: negative sum
		add_vertex(16'd0, 16'd0, 1'b0);
		add_vertex(16'd0, 16'd10, 1'b0);
		add_vertex(16'd10, 16'd0, 1'b1);
		// square wound twice: area saturates
		for (int i = 0; i < 8; i++)
			add_vertex(cx[i % 4], cy[i % 4], i == 7);
		// collinear: zero area
		add_vertex(16'd1, 16'd1, 1'b0);
		add_vertex(16'd2, 16'd2, 1'b0);
		add_vertex(16'd3, 16'd3, 1'b1);
		// small pentagon
		add_vertex(16'd0, 16'd0, 1'b0);
		add_vertex(16'd4, 16'd0, 1'b0);
		add_vertex(16'd5, 16'd3, 1'b0);
		add_vertex(16'd2, 16'd5, 1'b0);
		add_vertex(16'hFFFF, 16'd3, 1'b1);
		settle();

		// Square wound ten times: the area saturates and the count matches the target.
		set_target(16'd40);
		for (int i = 0; i < 40; i++)
			add_vertex(cx[i % 4], cy[i % 4], i == 39);
		settle();

		set_target(16'd0);
		random_polygons(150);
		settle();
		set_target(16'd2);
		random_polygons(150);
		settle();
		set_target(16'd3);
		random_polygons(200);
		settle();
		set_target(16'($urandom_range(4, 12)));
		random_polygons(250);
		settle();
		// last stretch runs at full rate on both sides
		set_target(16'd5);
		jitter_on = 1'b0;
		random_polygons(250);
		settle();

		if (errors == 0)
			$display("PASS polygon_area_statistics_unit");
		else
			$display("FAIL polygon_area_statistics_unit");
		$finish;
	end

endmodule

>>> sim.f
rtl/plg_pkg.sv
rtl/plg_vertex_stage.sv
rtl/plg_accum.sv
rtl/plg_stats.sv
rtl/polygon_area_statistics_unit.sv
tb/sv/polygon_area_statistics_unit_tb.sv
